// ===== rtl/crsm_pkg.sv =====
// Shared constants and types for the cubic resampling mixer.
`default_nettype none
package crsm_pkg;
    // Action codes carried by an input beat
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_PLAY = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;
    localparam logic [1:0] ACT_MIX  = 2'd3;

    // Fraction bits of the interpolation datapath
    localparam int QB = 17;
    // Width of the signed interpolation intermediates
    localparam int DW = 24;
    // Width of the saturating sum
    localparam int SUMW = 40;

    localparam logic [23:0] STEP_RESET = 24'd65536;

    typedef logic signed [DW-1:0] t_dat;
endpackage
`default_nettype wire

// ===== rtl/cubic_resample_saturating_mixer.sv =====
// Top level of the cubic resampling mixer.
`default_nettype none
// Plays a clip of signed 16-bit samples into a stereo stream. Load, play and
// stop beats finish in the accept cycle and their result is ready on the next
// cycle. A mix beat with a clip playing runs these steps once accepted: four
// neighbour reads stream through the registered read port of the sample RAM,
// then one coefficient step, three multiply and accumulate passes through one
// shared 18x24 multiplier and one saturation step, which waits while the
// result register is still held by a stall. The input stalls until the
// sequencer is idle and the result register is free. A mix beat with no clip
// playing finishes like a load. The sample RAM holds two banks of MAX_SAMPLES
// rounded up to a power of two and needs no clearing after reset.
module cubic_resample_saturating_mixer #(
    parameter int MAX_SAMPLES   = 4096,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_sample,
    input  wire logic signed [15:0] i_mix_left,
    input  wire logic signed [15:0] i_mix_right,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_out_left,
    output logic signed [15:0]      o_out_right,
    output logic                    o_playing,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    localparam int IW    = $clog2(MAX_SAMPLES);
    localparam int LW    = $clog2(MAX_SAMPLES + 1);
    localparam int CW    = LW + FRACTION_BITS;
    localparam int SW    = ((CW > 24) ? CW : 24) + 1;
    localparam int NW    = LW + 2;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int DW    = crsm_pkg::DW;
    localparam int QB    = crsm_pkg::QB;
    localparam int PW    = DW + QB + 1;
    localparam int SUMW  = crsm_pkg::SUMW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_COEF = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_SAT  = 3'd5;

    logic [2:0]              r_state;
    logic [23:0]             r_step;
    logic                    r_pend_bank;
    logic [LW-1:0]           r_pend_cnt;
    logic [LW-1:0]           r_len;
    logic [CW-1:0]           r_cursor;
    logic                    r_clip_valid;
    logic [2:0]              r_k;
    logic [1:0]              r_pass;
    logic signed [17:0]      r_p [4];
    crsm_pkg::t_dat          r_a, r_b, r_c, r_acc;
    logic signed [PW-1:0]    r_prod;
    logic signed [15:0]      r_ml, r_mr;
    logic                    r_ovalid;
    logic signed [15:0]      r_ol, r_or;
    logic                    r_oplay;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, r_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= crsm_pkg::STEP_RESET;
        end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
            r_step <= pwdata[23:0];
        end
    end

    // handshake
    logic out_free, accept;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign o_valid     = r_ovalid;
    assign o_out_left  = r_ol;
    assign o_out_right = r_or;
    assign o_playing   = r_oplay;

    // cursor split and fraction in Q.17
    logic [CW-1:0] clip_end;
    logic [LW-1:0] idx;
    logic [QB-1:0] t_frac;
    logic          playing_now;
    assign clip_end    = {r_len, {FRACTION_BITS{1'b0}}};
    assign idx         = r_cursor[CW-1:FRACTION_BITS];
    assign playing_now = r_clip_valid && (r_cursor < clip_end);

    // result register loads on a short beat or at the end of a mix
    logic out_load;
    assign out_load = (accept && !((i_action == crsm_pkg::ACT_MIX) && playing_now))
                      || ((r_state == S_SAT) && out_free);

    generate
        if (FRACTION_BITS >= QB) begin : g_frac_shr
            assign t_frac = r_cursor[FRACTION_BITS-1 -: QB];
        end else begin : g_frac_shl
            assign t_frac = {r_cursor[FRACTION_BITS-1:0], {(QB-FRACTION_BITS){1'b0}}};
        end
    endgenerate

    // clamped neighbour address
    logic signed [NW-1:0] nb, last;
    logic [LW-1:0]        nb_c;
    always_comb begin
        nb   = $signed({2'b00, idx}) + $signed({{(NW-3){1'b0}}, r_k}) - NW'(1);
        last = $signed({2'b00, r_len}) - NW'(1);
        if (nb > last) begin
            nb = last;
        end
        if (nb < 0) begin
            nb = '0;
        end
        nb_c = nb[LW-1:0];
    end

    // sample RAM: writes on load, reads during mix
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [15:0]     ram_rdata;
    assign ram_we    = accept && (i_action == crsm_pkg::ACT_LOAD)
                       && (r_pend_cnt < LW'(MAX_SAMPLES));
    assign ram_waddr = {r_pend_bank, r_pend_cnt[IW-1:0]};
    assign ram_raddr = {~r_pend_bank, nb_c[IW-1:0]};

    crsm_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_sample),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // shared multiplier operand and accumulate selection
    crsm_pkg::t_dat       mul_op, acc_add, acc_val;
    logic signed [PW-1:0] prod, prod_sh;
    always_comb begin
        mul_op  = (r_pass == 2'd0) ? r_c : r_acc;
        prod    = $signed({1'b0, t_frac}) * mul_op;
        acc_add = (r_pass == 2'd0) ? r_b : (r_pass == 2'd1) ? r_a : DW'(r_p[1]);
        prod_sh = (r_pass == 2'd2) ? (r_prod >>> (QB + 1)) : (r_prod >>> QB);
        acc_val = acc_add + prod_sh[DW-1:0];
    end

    // saturating add of speech to one channel, truncating toward zero
    function automatic logic signed [15:0] sat_mix(input logic signed [15:0] m,
                                                   input logic signed [SUMW-1:0] vs);
        logic signed [SUMW-1:0] s, hi, lo, ng, q;
        begin
            hi = SUMW'(32767) <<< QB;
            lo = -(SUMW'(32768) <<< QB);
            s  = (SUMW'(m) <<< QB) + vs;
            if (s > hi) begin
                s = hi;
            end
            if (s < lo) begin
                s = lo;
            end
            ng = -s;
            q  = s[SUMW-1] ? -(ng >>> QB) : (s >>> QB);
            sat_mix = q[15:0];
        end
    endfunction

    logic signed [SUMW-1:0] vs;
    logic [SW-1:0]          cur_sum;
    logic [CW-1:0]          cur_next;
    always_comb begin
        vs       = (SUMW'(r_acc) <<< 15) - SUMW'(r_acc);
        cur_sum  = SW'(r_cursor) + SW'(r_step);
        cur_next = (cur_sum > SW'(clip_end)) ? clip_end : cur_sum[CW-1:0];
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_bank  <= 1'b0;
            r_pend_cnt   <= '0;
            r_len        <= '0;
            r_cursor     <= '0;
            r_clip_valid <= 1'b0;
            r_ovalid     <= 1'b0;
            r_k          <= '0;
            r_pass       <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ml <= i_mix_left;
                        r_mr <= i_mix_right;
                        r_k  <= '0;
                        case (i_action)
                            crsm_pkg::ACT_LOAD: begin
                                if (r_pend_cnt < LW'(MAX_SAMPLES)) begin
                                    r_pend_cnt <= r_pend_cnt + LW'(1);
                                end
                                r_ol     <= '0;
                                r_or     <= '0;
                                r_oplay  <= playing_now;
                            end
                            crsm_pkg::ACT_PLAY: begin
                                r_ol     <= '0;
                                r_or     <= '0;
                                if (r_pend_cnt != '0) begin
                                    r_len        <= r_pend_cnt;
                                    r_clip_valid <= 1'b1;
                                    r_cursor     <= '0;
                                    r_pend_bank  <= ~r_pend_bank;
                                    r_pend_cnt   <= '0;
                                    r_oplay      <= 1'b1;
                                end else begin
                                    r_oplay <= playing_now;
                                end
                            end
                            crsm_pkg::ACT_STOP: begin
                                r_clip_valid <= 1'b0;
                                r_ol         <= '0;
                                r_or         <= '0;
                                r_oplay      <= 1'b0;
                            end
                            default: begin
                                if (playing_now) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_ol     <= i_mix_left;
                                    r_or     <= i_mix_right;
                                    r_oplay  <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // address goes out for neighbours 0..3, data returns in the next cycle
                    if (r_k != 3'd0) begin
                        r_p[0] <= r_p[1];
                        r_p[1] <= r_p[2];
                        r_p[2] <= r_p[3];
                        r_p[3] <= {ram_rdata, 2'b00};
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_COEF;
                    end
                end
                S_COEF: begin
                    r_a    <= DW'(r_p[2]) - DW'(r_p[0]);
                    r_b    <= DW'((DW'(r_p[0]) <<< 1) - DW'(r_p[1]) * 5
                                  + (DW'(r_p[2]) <<< 2) - DW'(r_p[3]));
                    r_c    <= DW'((DW'(r_p[1]) - DW'(r_p[2])) * 3
                                  + DW'(r_p[3]) - DW'(r_p[0]));
                    r_pass  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= acc_val;
                    if (r_pass == 2'd2) begin
                        r_state <= S_SAT;
                    end else begin
                        r_pass  <= r_pass + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_SAT: begin
                    // wait for the output register, then deliver and advance
                    if (out_free) begin
                        r_ol     <= sat_mix(r_ml, vs);
                        r_or     <= sat_mix(r_mr, vs);
                        r_oplay  <= cur_next < clip_end;
                        r_cursor <= cur_next;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/crsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module crsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
